// File: rtl/gfmd_pkg.sv
// shared types and constants for the gf(2^m) multiply / divide unit
`timescale 1ns / 1ps

package gfmd_pkg;

    // payload widths
    localparam int DATA_W         = 8;
    localparam int MODE_W         = 2;
    localparam int FIELD_SIZE_W   = 4;
    localparam int POLY_W         = 8;
    localparam int MAX_FIELD_BITS_DEF = 8;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIELD_SIZE     = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_REDUCTION_POLY = 1'd1;

    // register reset values
    localparam logic [FIELD_SIZE_W-1:0] FIELD_SIZE_RST     = 4'd8;
    localparam logic [POLY_W-1:0]       REDUCTION_POLY_RST = 8'h1D;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_MUL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUOT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REM  = 2'd2;

    // input beat
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } req_t;

    // output beat
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              divide_by_zero;
    } rsp_t;

endpackage

// File: rtl/gf2m_multiply_divide_unit.sv
// gf(2^m) multiply and gf(2) polynomial divide unit, top level
// sequence: a load step, then shift/xor steps for a multiply or a divide
//   (none for a zero divisor or the unused mode), then the result is registered
// one beat at a time: the next beat is taken once the result is registered, and a
//   stalled output delays that; the single shift/xor step unit is reused for each step
// reset: asynchronous, active low; field_size = 8, reduction_poly = 0x1d, unit idle
`timescale 1ns / 1ps

module gf2m_multiply_divide_unit
    import gfmd_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    // output channel
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int W  = MAX_FIELD_BITS;
    localparam int MW = $clog2(W + 1);
    localparam int CW = $clog2(W);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [FIELD_SIZE_W-1:0] field_size_reg;
    logic [POLY_W-1:0]       reduction_poly_reg;

    logic [1:0]        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      a_reg, a_next;
    logic [W-1:0]      b_reg, b_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     tpos_reg, tpos_next;
    logic              dz_reg, dz_next;

    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [MW-1:0]     eff_m;
    logic [W-1:0]      mask;
    logic [W-1:0]      poly_m;
    logic [W-1:0]      a_in;
    logic [W-1:0]      b_in;
    logic [MW-1:0]     b_deg;
    logic [MW-1:0]     shift_amt;
    logic [W-1:0]      res_sel;
    logic              step_bit;
    logic              load_rsp;
    logic              cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    logic [W+DATA_W-1:0] a_wide;
    logic [W+DATA_W-1:0] b_wide;
    logic [W+POLY_W-1:0] poly_wide;
    logic [W+DATA_W-1:0] res_wide;

    // degree of a polynomial: index of the top set bit plus one, zero for zero
    function automatic logic [MW-1:0] degree_of(input logic [W-1:0] v);
        logic [MW-1:0] d;
        d = '0;
        for (int i = 0; i < W; i++)
        begin
            if (v[i])
            begin
                d = MW'(i + 1);
            end
        end
        return d;
    endfunction

    // effective field degree, clamped to 1 .. MAX_FIELD_BITS
    always_comb
    begin
        if (field_size_reg == '0)
        begin
            eff_m = MW'(1);
        end
        else if (int'(field_size_reg) > W)
        begin
            eff_m = MW'(W);
        end
        else
        begin
            eff_m = MW'(field_size_reg);
        end
    end

    // operand mask of the low m bits
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            mask[i] = (i < int'(eff_m));
        end
    end

    // fit fixed-width fields to the internal word
    assign a_wide    = {{W{1'b0}}, req.operand_a};
    assign b_wide    = {{W{1'b0}}, req.operand_b};
    assign poly_wide = {{W{1'b0}}, reduction_poly_reg};
    assign a_in      = a_wide[W-1:0] & mask;
    assign b_in      = b_wide[W-1:0] & mask;
    assign poly_m    = poly_wide[W-1:0] & mask;

    // divisor alignment so its top bit sits at bit m-1
    assign b_deg     = degree_of(b_in);
    assign shift_amt = eff_m - b_deg;

    // bit under test: multiplicand carry-out or remainder lead term
    assign step_bit = a_reg[tpos_reg];

    // result selection by mode
    always_comb
    begin
        case (mode_reg)
            MODE_MUL:  res_sel = acc_reg;
            MODE_QUOT: res_sel = acc_reg;
            MODE_REM:  res_sel = a_reg;
            default:   res_sel = '0;
        endcase
    end

    assign res_wide = {{DATA_W{1'b0}}, res_sel & mask};
    assign load_rsp = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // sequencer and shared step unit
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        tpos_next  = tpos_reg;
        dz_next    = dz_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next = req.mode;
                    acc_next  = '0;
                    a_next    = a_in;
                    tpos_next = CW'(eff_m - MW'(1));
                    dz_next   = 1'b0;
                    if (req.mode == MODE_MUL)
                    begin
                        b_next     = b_in;
                        cnt_next   = CW'(eff_m - MW'(1));
                        state_next = ST_MUL;
                    end
                    else if (req.mode == MODE_QUOT || req.mode == MODE_REM)
                    begin
                        b_next   = b_in << shift_amt;
                        cnt_next = CW'(shift_amt);
                        if (b_in == '0)
                        begin
                            a_next     = '0;
                            dz_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg ^ a_reg;
                end
                a_next = ((a_reg << 1) & mask) ^ (step_bit ? poly_m : '0);
                b_next = b_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                a_next    = a_reg ^ (step_bit ? b_reg : '0);
                acc_next  = {acc_reg[W-2:0], step_bit};
                b_next    = b_reg >> 1;
                tpos_next = tpos_reg - CW'(1);
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and output beat
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        cnt_reg  <= cnt_next;
        tpos_reg <= tpos_next;
        dz_reg   <= dz_next;
        if (load_rsp)
        begin
            rsp_reg.result         <= res_wide[DATA_W-1:0];
            rsp_reg.divide_by_zero <= dz_reg;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_size_reg     <= FIELD_SIZE_RST;
            reduction_poly_reg <= REDUCTION_POLY_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_FIELD_SIZE:     field_size_reg     <= pwdata[FIELD_SIZE_W-1:0];
                REG_REDUCTION_POLY: reduction_poly_reg <= pwdata[POLY_W-1:0];
                default:            ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_FIELD_SIZE:     prdata = APB_DATA_W'(field_size_reg);
            REG_REDUCTION_POLY: prdata = APB_DATA_W'(reduction_poly_reg);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: bench/gf2m_multiply_divide_unit_tb.sv
// self-checking testbench for the gf(2^m) multiply / divide unit
`timescale 1ns / 1ps

module gf2m_multiply_divide_unit_tb;
    import gfmd_pkg::*;

    localparam int          MAX_BITS        = MAX_FIELD_BITS_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int          HOLD_OFF_CYCLES = 200;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          DRAIN_LIMIT     = 2000;
    localparam int          TAIL_CYCLES     = 20;
    localparam int          MAX_PRINTED     = 40;

    // one outstanding operation and the result it must give
    typedef struct {
        req_t item;
        rsp_t want;
    } gf_pending_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the field configuration
    logic [FIELD_SIZE_W-1:0] cfg_field_size = FIELD_SIZE_RST;
    logic [POLY_W-1:0]       cfg_poly       = REDUCTION_POLY_RST;

    gf_pending_t pending_results[$];

    int  error_count        = 0;
    int  requests_sent      = 0;
    int  results_checked    = 0;
    int  zero_divisor_seen  = 0;
    int  settings_used      = 1;
    bit  steady_flow        = 1'b0;
    int  stall_asks         = 0;
    int  stalls_served      = 0;
    int  hold_left          = 0;

    gf2m_multiply_divide_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // field degree after clamping to 1..max
    function automatic int unsigned field_width();
        int unsigned m;
        m = 32'(cfg_field_size);
        if (m < 1)
            m = 1;
        if (m > MAX_BITS)
            m = MAX_BITS;
        return m;
    endfunction

    // degree + 1 of a gf(2) polynomial, 0 for the zero polynomial
    function automatic int unsigned poly_degree(input logic [DATA_W-1:0] v);
        int unsigned n;
        n = 0;
        for (int i = 0; i < DATA_W; i++)
            if (v[i])
                n = i + 1;
        return n;
    endfunction

    // expected product, quotient or remainder under the current field setting
    function automatic rsp_t predict_gf_result(input req_t item);
        int unsigned       m;
        int unsigned       db;
        int unsigned       dr;
        int unsigned       d;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] r;
        logic              carry;
        rsp_t              out;
        m    = field_width();
        mask = DATA_W'((1 << m) - 1);
        a    = item.operand_a & mask;
        b    = item.operand_b & mask;
        out  = '0;
        case (item.mode) inside
            MODE_MUL:
            begin
                // shift-and-add, reduce whenever bit m-1 falls out
                acc = '0;
                p   = cfg_poly & mask;
                for (int i = 0; i < m; i++)
                begin
                    if (b[i])
                        acc ^= a;
                    carry = a[m-1];
                    a     = (a << 1) & mask;
                    if (carry)
                        a ^= p;
                end
                out.result = acc;
            end
            MODE_QUOT, MODE_REM:
            begin
                if (b == '0)
                    out.divide_by_zero = 1'b1;
                else
                begin
                    // long division over gf(2)
                    q  = '0;
                    r  = a;
                    db = poly_degree(b);
                    for (int i = 0; i <= m && r != '0; i++)
                    begin
                        dr = poly_degree(r);
                        if (dr < db)
                            break;
                        d = dr - db;
                        q ^= DATA_W'(1 << d);
                        r ^= DATA_W'(b << d);
                    end
                    out.result = (item.mode == MODE_QUOT) ? q : r;
                end
            end
            default: ;
        endcase
        out.result &= mask;
        return out;
    endfunction

    function automatic req_t make_req(input logic [MODE_W-1:0] mode,
                                      input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b);
        req_t item;
        item.mode      = mode;
        item.operand_a = a;
        item.operand_b = b;
        return item;
    endfunction

    // random operation; some divisors carry only bits above the field width
    function automatic req_t random_gf_item();
        req_t              item;
        int unsigned       pick;
        logic [DATA_W-1:0] mask;
        mask = DATA_W'((1 << field_width()) - 1);
        pick = $urandom_range(99);
        if (pick < 32)
            item.mode = MODE_MUL;
        else if (pick < 64)
            item.mode = MODE_QUOT;
        else if (pick < 94)
            item.mode = MODE_REM;
        else
            item.mode = MODE_UNUSED;
        item.operand_a = DATA_W'($urandom);
        item.operand_b = DATA_W'($urandom);
        if ($urandom_range(99) < 8)
            item.operand_b &= ~mask;
        return item;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // offer one beat, wait for the handshake, record the expected result
    task automatic send_item(input req_t item);
        logic        took;
        gf_pending_t entry;
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 9)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(negedge clk);
            took = req_ready;
            @(posedge clk);
        end
        while (!took);
        entry.item = item;
        entry.want = predict_gf_result(item);
        pending_results.push_back(entry);
        requests_sent++;
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        logic                  done;
        logic [APB_DATA_W-1:0] readback;
        logic [APB_DATA_W-1:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        if (idx == REG_FIELD_SIZE)
            cfg_field_size = value[FIELD_SIZE_W-1:0];
        else
            cfg_poly = value[POLY_W-1:0];
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done     = pready;
            readback = prdata;
            @(posedge clk);
        end
        while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        stored = (idx == REG_FIELD_SIZE) ? APB_DATA_W'(cfg_field_size)
                                         : APB_DATA_W'(cfg_poly);
        if (readback !== stored)
            report_mismatch($sformatf("register %0d read %h, wrote %h", idx, readback, stored));
    endtask

    task automatic apply_setting(input logic [FIELD_SIZE_W-1:0] size,
                                 input logic [POLY_W-1:0] poly);
        drain_results();
        write_register(REG_FIELD_SIZE, APB_DATA_W'(size));
        write_register(REG_REDUCTION_POLY, APB_DATA_W'(poly));
        settings_used++;
    endtask

    // extremes and special cases at the reset setting (m = 8, poly 0x1d)
    task automatic test_directed_cases();
        send_item(make_req(MODE_MUL, 8'hFF, 8'hFF));
        send_item(make_req(MODE_MUL, 8'h00, 8'hFF));
        send_item(make_req(MODE_MUL, 8'hFF, 8'h00));
        send_item(make_req(MODE_MUL, 8'h80, 8'h02));
        send_item(make_req(MODE_MUL, 8'h01, 8'hAB));
        send_item(make_req(MODE_MUL, 8'h53, 8'hCA));
        send_item(make_req(MODE_QUOT, 8'hFF, 8'h01));
        send_item(make_req(MODE_REM, 8'hFF, 8'h01));
        // zero divisor
        send_item(make_req(MODE_QUOT, 8'h5A, 8'h00));
        send_item(make_req(MODE_REM, 8'h5A, 8'h00));
        send_item(make_req(MODE_QUOT, 8'h00, 8'h00));
        // dividend of lower degree than the divisor, then further divisions
        send_item(make_req(MODE_QUOT, 8'h03, 8'h80));
        send_item(make_req(MODE_REM, 8'h03, 8'h80));
        send_item(make_req(MODE_QUOT, 8'hFF, 8'hFF));
        send_item(make_req(MODE_REM, 8'hB5, 8'h0B));
        send_item(make_req(MODE_QUOT, 8'h00, 8'h37));
        // unused mode
        send_item(make_req(MODE_UNUSED, 8'hFF, 8'hFF));
        send_item(make_req(MODE_UNUSED, 8'h00, 8'h00));
    endtask

    // field sizes 0 to 9 and 15 incl. out-of-range ones, polys with bits above m
    task automatic test_field_sizes();
        logic [FIELD_SIZE_W-1:0] sizes [14];
        logic [POLY_W-1:0]       polys [14];
        logic [DATA_W-1:0]       mask;
        sizes = '{4'd1, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                  4'd7, 4'd8, 4'd8, 4'd15, 4'd9, 4'd4, 4'd3};
        polys = '{8'h01, 8'hFF, 8'h03, 8'h03, 8'h03, 8'h05, 8'h03,
                  8'h09, 8'h00, 8'hFF, 8'h1D, 8'hAB, 8'hF3, 8'hFB};
        for (int s = 0; s < 14; s++)
        begin
            apply_setting(sizes[s], polys[s]);
            mask = DATA_W'((1 << field_width()) - 1);
            send_item(make_req(MODE_MUL, 8'hFF, 8'hFF));
            send_item(make_req(MODE_QUOT, 8'hFF, ~mask));
            send_item(make_req(MODE_REM, 8'hFF, 8'h01));
            repeat (60)
                send_item(random_gf_item());
        end
    endtask

    // random settings, two of them with no idling on either side
    task automatic test_random_settings();
        for (int s = 0; s < 6; s++)
        begin
            apply_setting(FIELD_SIZE_W'($urandom_range(15)), POLY_W'($urandom_range(255)));
            steady_flow = (s == 2 || s == 3);
            repeat (120)
                send_item(random_gf_item());
        end
        steady_flow = 1'b0;
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        apply_setting(4'd8, 8'h1D);
        steady_flow = 1'b1;
        stall_asks++;
        repeat (40)
            send_item(random_gf_item());
        steady_flow = 1'b0;
    endtask

    // sender pauses until the unit has returned everything
    task automatic test_drain_pause();
        repeat (20)
            send_item(random_gf_item());
        drain_results();
        repeat (20)
            send_item(random_gf_item());
    endtask

    // result side ready, with random stalls and requested hold-offs
    always @(posedge clk)
    begin
        if (stall_asks != stalls_served)
        begin
            stalls_served = stall_asks;
            hold_left     = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (steady_flow)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(99) >= 9);
    end

    // compare each result beat with the oldest expectation
    always @(negedge clk)
    begin : result_checker
        gf_pending_t head;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %h with nothing outstanding", rsp));
            else
            begin
                head = pending_results.pop_front();
                results_checked++;
                if (head.want.divide_by_zero)
                    zero_divisor_seen++;
                if (rsp.result !== head.want.result)
                    report_mismatch($sformatf("mode %0d a %h b %h: result %h, want %h",
                        head.item.mode, head.item.operand_a, head.item.operand_b,
                        rsp.result, head.want.result));
                if (rsp.divide_by_zero !== head.want.divide_by_zero)
                    report_mismatch($sformatf("mode %0d a %h b %h: zero flag %b, want %b",
                        head.item.mode, head.item.operand_a, head.item.operand_b,
                        rsp.divide_by_zero, head.want.divide_by_zero));
            end
        end
    end

    // end the run when no beat moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // test sequence
    initial
    begin : test_sequence
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_field_sizes();
        test_random_settings();
        test_output_backpressure();
        test_drain_pause();
        // final drain, then a quiet tail to catch stray beats
        req_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d operations over %0d field settings, all modes incl. unused",
                 requests_sent, settings_used);
        $display("%0d results checked, %0d zero-divisor results, %0d mismatches",
                 results_checked, zero_divisor_seen, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
